// ===== hdl/ncpe_pkg.sv =====
// shared types and codes for the nurbs curve point evaluator
// used by nurbs_curve_point_eval_core and ncpe_div, no dependencies
`default_nettype none

package ncpe_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_MAX_DEGREE = 7;

    localparam int QB = 16;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    // item kinds on the input channel
    localparam logic [1:0] MODE_POINT = 2'd0;
    localparam logic [1:0] MODE_KNOT  = 2'd1;
    localparam logic [1:0] MODE_EVAL  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DEGREE = 2'd0;
    localparam logic [1:0] CFG_POINTS = 2'd1;
    localparam logic [1:0] CFG_KNOTS  = 2'd2;
    localparam logic [1:0] CFG_UNITW  = 2'd3;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_KF,
        S_KF_MEM,
        S_KF_DIV,
        S_SPAN_HI,
        S_SPAN_LO,
        S_BS_A,
        S_BS_B,
        S_B_START,
        S_B_LF,
        S_B_RT,
        S_B_DN,
        S_B_DIV,
        S_B_M1,
        S_B_M2,
        S_B_M3,
        S_S_RD,
        S_S_W,
        S_S_C,
        S_S_X,
        S_S_Y,
        S_S_Z,
        S_S_ACC,
        S_F_DEN,
        S_F_DX,
        S_F_DY,
        S_F_DZ,
        S_OUT
    } ncpe_state_t;

endpackage

`default_nettype wire

// ===== hdl/nurbs_curve_point_eval_core.sv =====
// nurbs curve point evaluator: point and knot stores, span search,
// cox-de boor basis and rational sum on one multiplier and one divider
// depends on ncpe_pkg and ncpe_div
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: mode; tdata: index, pos_x, pos_y, pos_z,
//                                  weight, knot_value, param_u
// m_*      out  m_tvalid/m_tready  tuser: status; tdata: out_x, out_y, out_z
// cfg_*    in   cfg_we             cfg_index: register, cfg_data: value
//
// point and knot writes are taken only in idle; an evaluate item keeps the core busy
// through span search (binary search over the knots when needed), basis and rational sum;
// with knots not loaded, each generated inner knot fetched is a division on the 48-step
// divider. s_tready is high only in idle; a finished result moves to the
// output register and the sequencer waits only while that register is still full.
// rst_n clears the sequencer, the output valid and the configuration; stores are not cleared.
`default_nettype none

module nurbs_curve_point_eval_core #(
    parameter int MAX_POINTS = ncpe_pkg::DEF_MAX_POINTS,
    parameter int MAX_DEGREE = ncpe_pkg::DEF_MAX_DEGREE
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [199:0] s_tdata,   // index, pos_x, pos_y, pos_z, weight, knot_value, param_u
    input  wire  [1:0]   s_tuser,   // mode
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [95:0]  m_tdata,   // out_x, out_y, out_z
    output logic [1:0]   m_tuser,   // status
    input  wire          cfg_we,
    input  wire  [1:0]   cfg_index,
    input  wire  [6:0]   cfg_data
);
    import ncpe_pkg::*;

    localparam int KD   = MAX_POINTS + MAX_DEGREE + 1;
    localparam int KW   = ($clog2(KD + 1) > 7) ? $clog2(KD + 1) : 7;
    localparam int PAW  = $clog2(MAX_POINTS);
    localparam int KAW  = $clog2(KD);
    localparam int DAW  = $clog2(MAX_DEGREE + 1);
    localparam int JW   = $clog2(MAX_DEGREE + 2);
    localparam int ND   = MAX_DEGREE + 1;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fff_ffff;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // input fields
    logic [6:0]         in_index;
    logic signed [31:0] in_x, in_y, in_z, in_w, in_knot, in_u;
    assign in_index = s_tdata[6:0];
    assign in_x     = s_tdata[38:7];
    assign in_y     = s_tdata[70:39];
    assign in_z     = s_tdata[102:71];
    assign in_w     = s_tdata[134:103];
    assign in_knot  = s_tdata[166:135];
    assign in_u     = s_tdata[198:167];

    // configuration
    logic [2:0] degree_reg;
    logic [6:0] point_count_reg;
    logic [6:0] knot_count_reg;
    logic       unit_weights_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg       <= 3'd3;
            point_count_reg  <= 7'd0;
            knot_count_reg   <= 7'd0;
            unit_weights_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEGREE: degree_reg       <= cfg_data[2:0];
                CFG_POINTS: point_count_reg  <= cfg_data;
                CFG_KNOTS:  knot_count_reg   <= cfg_data;
                CFG_UNITW:  unit_weights_reg <= cfg_data[0];
            endcase
        end
    end

    logic [KW-1:0] p, cnt, idx_k;
    logic          knot_loaded, few_pts;

    always_comb
    begin
        if (degree_reg == 3'd0)
            p = KW'(1);
        else if (KW'(degree_reg) > KW'(MAX_DEGREE))
            p = KW'(MAX_DEGREE);
        else
            p = KW'(degree_reg);
        if (KW'(point_count_reg) > KW'(MAX_POINTS))
            cnt = KW'(MAX_POINTS);
        else
            cnt = KW'(point_count_reg);
    end

    assign knot_loaded = KW'(knot_count_reg) == (cnt + p + KW'(1));
    assign few_pts     = cnt < (p + KW'(1));
    assign idx_k       = KW'(in_index);

    // sequencer and datapath registers
    ncpe_state_t state_reg, state_next;
    ncpe_state_t ret_reg, ret_next;

    logic signed [31:0] u_reg, u_next;
    logic [KW-1:0]      span_reg, span_next;
    logic [KW-1:0]      lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [KW-1:0]      kidx_reg, kidx_next;
    logic signed [31:0] knot_reg, knot_next, kmid_reg, kmid_next;
    logic [JW-1:0]      j_reg, j_next, r_reg, r_next;
    logic signed [31:0] saved_reg, saved_next, t_reg, t_next, c_reg, c_next;
    logic signed [31:0] den_reg, den_next;
    logic signed [31:0] nb_reg [ND];
    logic signed [31:0] nb_next [ND];
    logic signed [31:0] lf_reg [ND];
    logic signed [31:0] lf_next [ND];
    logic signed [31:0] rt_reg [ND];
    logic signed [31:0] rt_next [ND];
    logic signed [63:0] prod_reg;
    logic signed [51:0] sx_reg, sx_next, sy_reg, sy_next, sz_reg, sz_next;
    logic signed [51:0] sw_reg, sw_next;
    logic signed [31:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic [1:0]         status_reg, status_next;

    // output register
    logic               mv_reg, mv_next;
    logic [95:0]        md_reg, md_next;
    logic [1:0]         ms_reg, ms_next;
    logic               out_load;

    // memories
    logic [127:0]       ctrl_mem [MAX_POINTS];
    logic [127:0]       ctrl_rd_reg;
    logic signed [31:0] knot_mem [KD];
    logic signed [31:0] knot_rd_reg;
    logic [KW-1:0]      caddr;

    assign caddr = span_reg - p + KW'(j_reg);

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready && s_tuser == MODE_POINT && idx_k < KW'(MAX_POINTS))
            ctrl_mem[idx_k[PAW-1:0]] <= {in_w, in_z, in_y, in_x};
        ctrl_rd_reg <= ctrl_mem[caddr[PAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready && s_tuser == MODE_KNOT && idx_k < KW'(KD))
            knot_mem[idx_k[KAW-1:0]] <= in_knot;
        knot_rd_reg <= knot_mem[kidx_reg[KAW-1:0]];
    end

    logic signed [31:0] cx, cy, cz, cw;
    assign cx = ctrl_rd_reg[31:0];
    assign cy = ctrl_rd_reg[63:32];
    assign cz = ctrl_rd_reg[95:64];
    assign cw = ctrl_rd_reg[127:96];

    // shared divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    ncpe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // shared multiplier
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic signed [47:0] qm;
    logic [JW-1:0]      rp1, jmr;
    logic signed [31:0] rt_r, lf_r, nb_r, nb_j, dn;
    logic               bs_more;
    logic [KW:0]        lohi_sum;
    logic [KW-1:0]      lo_upd, hi_upd;

    assign rp1  = r_reg + JW'(1);
    assign jmr  = j_reg - r_reg;
    assign rt_r = rt_reg[rp1[DAW-1:0]];
    assign lf_r = lf_reg[jmr[DAW-1:0]];
    assign nb_r = nb_reg[r_reg[DAW-1:0]];
    assign nb_j = nb_reg[j_reg[DAW-1:0]];
    assign dn   = sat32(64'(rt_r) + 64'(lf_r));
    assign qm   = $signed(prod_reg[63:16]);

    // binary search step
    assign bs_more  = ((hi_reg - lo_reg) > KW'(1)) && (u_reg < kmid_reg || u_reg >= knot_reg);
    assign lo_upd   = (u_reg < kmid_reg) ? lo_reg : mid_reg;
    assign hi_upd   = (u_reg < kmid_reg) ? mid_reg : hi_reg;
    assign lohi_sum = {1'b0, lo_upd} + {1'b0, hi_upd};

    assign out_load = (state_reg == S_OUT) && (!mv_reg || m_tready);

    always_comb
    begin
        mul_a = rt_r;
        mul_b = t_reg;
        unique case (state_reg)
            S_B_M2:
            begin
                mul_a = lf_r;
                mul_b = t_reg;
            end
            S_S_W:
            begin
                mul_a = nb_j;
                mul_b = unit_weights_reg ? Q_ONE : cw;
            end
            S_S_X:
            begin
                mul_a = c_reg;
                mul_b = cx;
            end
            S_S_Y:
            begin
                mul_a = c_reg;
                mul_b = cy;
            end
            S_S_Z:
            begin
                mul_a = c_reg;
                mul_b = cz;
            end
            default:
            begin
                mul_a = rt_r;
                mul_b = t_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_tvalid && s_tuser == MODE_EVAL)
                    state_next = S_CHECK;
            S_CHECK:
                state_next = few_pts ? S_OUT : S_KF;
            S_KF:
                if (knot_loaded)
                    state_next = S_KF_MEM;
                else if (kidx_reg <= p || kidx_reg >= cnt)
                    state_next = ret_reg;
                else
                    state_next = S_KF_DIV;
            S_KF_MEM:
                state_next = ret_reg;
            S_KF_DIV:
                if (div_rsp.done)
                    state_next = ret_reg;
            S_SPAN_HI:
                state_next = (u_reg >= knot_reg) ? S_B_START : S_KF;
            S_SPAN_LO:
                state_next = (u_reg <= knot_reg) ? S_B_START : S_KF;
            S_BS_A:
                state_next = S_KF;
            S_BS_B:
                state_next = bs_more ? S_KF : S_B_START;
            S_B_START:
                state_next = S_KF;
            S_B_LF:
                state_next = S_KF;
            S_B_RT:
                state_next = S_B_DN;
            S_B_DN:
                state_next = (dn != 32'sd0) ? S_B_DIV : S_B_M1;
            S_B_DIV:
                if (div_rsp.done)
                    state_next = S_B_M1;
            S_B_M1:
                state_next = S_B_M2;
            S_B_M2:
                state_next = S_B_M3;
            S_B_M3:
                if (rp1 < j_reg)
                    state_next = S_B_DN;
                else if (KW'(j_reg) < p)
                    state_next = S_KF;
                else
                    state_next = S_S_RD;
            S_S_RD:
                state_next = S_S_W;
            S_S_W:
                state_next = S_S_C;
            S_S_C:
                state_next = S_S_X;
            S_S_X:
                state_next = S_S_Y;
            S_S_Y:
                state_next = S_S_Z;
            S_S_Z:
                state_next = S_S_ACC;
            S_S_ACC:
                state_next = (KW'(j_reg) < p) ? S_S_RD : S_F_DEN;
            S_F_DEN:
                state_next = (sat32(64'(sw_reg)) == 32'sd0) ? S_OUT : S_F_DX;
            S_F_DX:
                if (div_rsp.done)
                    state_next = S_F_DY;
            S_F_DY:
                if (div_rsp.done)
                    state_next = S_F_DZ;
            S_F_DZ:
                if (div_rsp.done)
                    state_next = S_OUT;
            S_OUT:
                if (!mv_reg || m_tready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        ret_next    = ret_reg;
        u_next      = u_reg;
        span_next   = span_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        kidx_next   = kidx_reg;
        knot_next   = knot_reg;
        kmid_next   = kmid_reg;
        j_next      = j_reg;
        r_next      = r_reg;
        saved_next  = saved_reg;
        t_next      = t_reg;
        c_next      = c_reg;
        den_next    = den_reg;
        nb_next     = nb_reg;
        lf_next     = lf_reg;
        rt_next     = rt_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        sz_next     = sz_reg;
        sw_next     = sw_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oz_next     = oz_reg;
        status_next = status_reg;
        div_req     = '0;

        unique case (state_reg)
            S_IDLE:
                u_next = in_u;
            S_CHECK:
            begin
                ox_next     = '0;
                oy_next     = '0;
                oz_next     = '0;
                status_next = ST_FEW;
                kidx_next   = cnt;
                ret_next    = S_SPAN_HI;
            end
            S_KF:
                if (!knot_loaded)
                begin
                    if (kidx_reg <= p)
                        knot_next = '0;
                    else if (kidx_reg >= cnt)
                        knot_next = Q_ONE;
                    else
                    begin
                        // inner open-uniform knot (i - p) / (n - p)
                        div_req.start = 1'b1;
                        div_req.num   = 32'(kidx_reg - p);
                        div_req.den   = 32'(cnt - p);
                    end
                end
            S_KF_MEM:
                knot_next = knot_rd_reg;
            S_KF_DIV:
                if (div_rsp.done)
                    knot_next = div_rsp.quo;
            S_SPAN_HI:
                if (u_reg >= knot_reg)
                    span_next = cnt - KW'(1);
                else
                begin
                    kidx_next = p;
                    ret_next  = S_SPAN_LO;
                end
            S_SPAN_LO:
                if (u_reg <= knot_reg)
                    span_next = p;
                else
                begin
                    lo_next   = p;
                    hi_next   = cnt;
                    mid_next  = KW'(({1'b0, p} + {1'b0, cnt}) >> 1);
                    kidx_next = KW'(({1'b0, p} + {1'b0, cnt}) >> 1);
                    ret_next  = S_BS_A;
                end
            S_BS_A:
            begin
                kmid_next = knot_reg;
                kidx_next = mid_reg + KW'(1);
                ret_next  = S_BS_B;
            end
            S_BS_B:
                if (bs_more)
                begin
                    lo_next   = lo_upd;
                    hi_next   = hi_upd;
                    mid_next  = KW'(lohi_sum >> 1);
                    kidx_next = KW'(lohi_sum >> 1);
                    ret_next  = S_BS_A;
                end
                else
                    span_next = mid_reg;
            S_B_START:
            begin
                nb_next[0] = Q_ONE;
                j_next     = JW'(1);
                kidx_next  = span_reg;
                ret_next   = S_B_LF;
            end
            S_B_LF:
            begin
                lf_next[j_reg[DAW-1:0]] = sat32(64'(u_reg) - 64'(knot_reg));
                kidx_next = span_reg + KW'(j_reg);
                ret_next  = S_B_RT;
            end
            S_B_RT:
            begin
                rt_next[j_reg[DAW-1:0]] = sat32(64'(knot_reg) - 64'(u_reg));
                r_next     = '0;
                saved_next = '0;
            end
            S_B_DN:
                if (dn != 32'sd0)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = nb_r;
                    div_req.den   = dn;
                end
                else
                    t_next = '0;
            S_B_DIV:
                if (div_rsp.done)
                    t_next = div_rsp.quo;
            S_B_M1:
            begin
            end
            S_B_M2:
                nb_next[r_reg[DAW-1:0]] = sat32(64'(saved_reg) + 64'(qm));
            S_B_M3:
            begin
                saved_next = sat32(64'(qm));
                if (rp1 < j_reg)
                    r_next = rp1;
                else
                begin
                    nb_next[j_reg[DAW-1:0]] = sat32(64'(qm));
                    if (KW'(j_reg) < p)
                    begin
                        j_next    = j_reg + JW'(1);
                        kidx_next = span_reg - KW'(j_reg);
                        ret_next  = S_B_LF;
                    end
                    else
                    begin
                        j_next  = '0;
                        sx_next = '0;
                        sy_next = '0;
                        sz_next = '0;
                        sw_next = '0;
                    end
                end
            end
            S_S_RD:
            begin
            end
            S_S_W:
            begin
            end
            S_S_C:
            begin
                c_next  = sat32(64'(qm));
                sw_next = sw_reg + 52'(sat32(64'(qm)));
            end
            S_S_X:
            begin
            end
            S_S_Y:
                sx_next = sx_reg + 52'(qm);
            S_S_Z:
                sy_next = sy_reg + 52'(qm);
            S_S_ACC:
            begin
                sz_next = sz_reg + 52'(qm);
                if (KW'(j_reg) < p)
                    j_next = j_reg + JW'(1);
            end
            S_F_DEN:
            begin
                den_next = sat32(64'(sw_reg));
                if (sat32(64'(sw_reg)) == 32'sd0)
                    status_next = ST_ZERO;
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = sat32(64'(sx_reg));
                    div_req.den   = sat32(64'(sw_reg));
                end
            end
            S_F_DX:
                if (div_rsp.done)
                begin
                    ox_next       = div_rsp.quo;
                    div_req.start = 1'b1;
                    div_req.num   = sat32(64'(sy_reg));
                    div_req.den   = den_reg;
                end
            S_F_DY:
                if (div_rsp.done)
                begin
                    oy_next       = div_rsp.quo;
                    div_req.start = 1'b1;
                    div_req.num   = sat32(64'(sz_reg));
                    div_req.den   = den_reg;
                end
            S_F_DZ:
                if (div_rsp.done)
                begin
                    oz_next     = div_rsp.quo;
                    status_next = ST_OK;
                end
            S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // output register: loads a finished result, clears when taken
    always_comb
    begin
        mv_next = mv_reg;
        md_next = md_reg;
        ms_next = ms_reg;
        if (mv_reg && m_tready)
            mv_next = 1'b0;
        if (out_load)
        begin
            mv_next = 1'b1;
            md_next = {oz_reg, oy_reg, ox_reg};
            ms_next = status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        span_reg   <= span_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        kidx_reg   <= kidx_next;
        knot_reg   <= knot_next;
        kmid_reg   <= kmid_next;
        j_reg      <= j_next;
        r_reg      <= r_next;
        saved_reg  <= saved_next;
        t_reg      <= t_next;
        c_reg      <= c_next;
        den_reg    <= den_next;
        nb_reg     <= nb_next;
        lf_reg     <= lf_next;
        rt_reg     <= rt_next;
        prod_reg   <= mul_p;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        sz_reg     <= sz_next;
        sw_reg     <= sw_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        oz_reg     <= oz_next;
        status_reg <= status_next;
        md_reg     <= md_next;
        ms_reg     <= ms_next;
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = ms_reg;

endmodule

`default_nettype wire

// ===== hdl/ncpe_div.sv =====
// shared q16.16 divider: (num * 2^16) / den, truncated toward zero, saturated
// one quotient bit per cycle, depends on ncpe_pkg
`default_nettype none

module ncpe_div (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ncpe_pkg::div_req_t   req,
    output ncpe_pkg::div_rsp_t   rsp
);
    import ncpe_pkg::*;

    localparam int DIV_STEPS = 32 + QB;
    localparam int SW = $clog2(DIV_STEPS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [SW-1:0]         step_reg, step_next;
    logic                  neg_reg, neg_next;
    logic [DIV_STEPS-1:0]  dnd_reg, dnd_next;
    logic [31:0]           rem_reg, rem_next;
    logic [31:0]           dvs_reg, dvs_next;
    logic signed [31:0]    quo_reg, quo_next;

    logic [31:0]           num_mag, den_mag;
    logic [32:0]           rem_sh;
    logic                  ge;
    logic [DIV_STEPS-1:0]  dnd_step;
    logic [31:0]           rem_step;

    assign num_mag  = req.num[31] ? (~req.num + 32'd1) : req.num;
    assign den_mag  = req.den[31] ? (~req.den + 32'd1) : req.den;
    assign rem_sh   = {rem_reg, dnd_reg[DIV_STEPS-1]};
    assign ge       = rem_sh >= {1'b0, dvs_reg};
    assign rem_step = ge ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
    assign dnd_step = {dnd_reg[DIV_STEPS-2:0], ge};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        dnd_next  = dnd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = req.num[31] ^ req.den[31];
            dnd_next  = {num_mag, {QB{1'b0}}};
            rem_next  = '0;
            dvs_next  = den_mag;
        end
        else if (busy_reg)
        begin
            dnd_next  = dnd_step;
            rem_next  = rem_step;
            step_next = step_reg + SW'(1);
            if (step_reg == SW'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                // saturate the magnitude to the signed 32-bit range
                if (neg_reg)
                begin
                    if (dnd_step > DIV_STEPS'(33'h0_8000_0000))
                        quo_next = 32'sh8000_0000;
                    else
                        quo_next = -$signed(dnd_step[31:0]);
                end
                else
                begin
                    if (dnd_step > DIV_STEPS'(32'h7fff_ffff))
                        quo_next = 32'sh7fff_ffff;
                    else
                        quo_next = $signed(dnd_step[31:0]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dnd_reg <= dnd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire
